/* rtl/core/osst_pkg.sv */
`timescale 1ns / 1ps
package osst_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned OUT_COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic add;
    logic remove;
  } cell_ctrl_t;

endpackage

/* rtl/core/osst_if.sv */
`timescale 1ns / 1ps
interface osst_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [osst_pkg::MODE_W-1:0]             mode;
  logic signed [osst_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface osst_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic                                changed;
  logic                                full_reject;
  logic [osst_pkg::OUT_COUNT_W-1:0]    member_count;
  logic                                is_empty;

  modport source (output valid, output found, output changed, output full_reject,
                  output member_count, output is_empty, input ready);
  modport sink   (input valid, input found, input changed, input full_reject,
                  input member_count, input is_empty, output ready);
endinterface

/* rtl/core/ordered_set_store.sv */
`timescale 1ns / 1ps
// Each request passes ST_IDLE (accept), ST_CMP and ST_UPD; the result is registered in ST_UPD,
//   which waits while the output is stalled. A new request is accepted only in ST_IDLE;
//   the cell row compares in ST_CMP and resolves the hit chain and shift in ST_UPD.
// Reset (rst_n low, synchronous): member count cleared, controller idle, no result pending.
// Slot contents are not reset; only live slots are ever compared.
module ordered_set_store #(
  parameter int unsigned CAPACITY = osst_pkg::DEF_CAPACITY
) (
  input logic        clk,
  input logic        rst_n,
  osst_in_if.sink    in_ch,
  osst_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t                           state_r;
  logic [osst_pkg::MODE_W-1:0]      mode_r;
  logic [osst_pkg::VALUE_W-1:0]     value_r;
  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 count_nxt;
  logic                             out_valid_r;
  logic                             found_r;
  logic                             changed_r;
  logic                             reject_r;
  logic [osst_pkg::OUT_COUNT_W-1:0] member_count_r;
  logic                             is_empty_r;

  logic                             out_free;
  logic                             upd_go;
  logic                             found;
  logic                             changed;
  logic                             reject;
  osst_pkg::cell_ctrl_t             ctrl;
  logic [CAPACITY:0]                seen;
  logic [osst_pkg::VALUE_W-1:0]     slot_q [CAPACITY];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign upd_go      = (state_r == ST_UPD) && out_free;
  assign found       = seen[CAPACITY];

  always_comb begin
    count_nxt = count_r;
    changed   = 1'b0;
    reject    = 1'b0;
    unique case (osst_pkg::mode_t'(mode_r))
      osst_pkg::MODE_ADD: begin
        if (!found) begin
          if (count_r < CAP_C) begin
            count_nxt = count_r + CNT_W'(1);
            changed   = 1'b1;
          end else begin
            reject = 1'b1;
          end
        end
      end
      osst_pkg::MODE_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
          changed   = 1'b1;
        end
      end
      osst_pkg::MODE_LOOKUP: begin
      end
      osst_pkg::MODE_CLEAR: begin
        count_nxt = '0;
        changed   = (count_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en = (state_r == ST_CMP);
    ctrl.upd_en = upd_go;
    ctrl.add    = (mode_r == osst_pkg::MODE_ADD) && !found && (count_r < CAP_C);
    ctrl.remove = (mode_r == osst_pkg::MODE_REMOVE);
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [osst_pkg::VALUE_W-1:0] up;
    if (i == CAPACITY - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = slot_q[i+1];
    end
    osst_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count_r),
      .value    (value_r),
      .slot_up  (up),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .slot_q   (slot_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            mode_r  <= in_ch.mode;
            value_r <= in_ch.value;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            count_r        <= count_nxt;
            found_r        <= found && (mode_r != osst_pkg::MODE_CLEAR);
            changed_r      <= changed;
            reject_r       <= reject;
            member_count_r <= osst_pkg::OUT_COUNT_W'(count_nxt);
            is_empty_r     <= (count_nxt == '0);
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.changed      = changed_r;
  assign out_ch.full_reject  = reject_r;
  assign out_ch.member_count = member_count_r;
  assign out_ch.is_empty     = is_empty_r;

endmodule

/* rtl/core/osst_cell.sv */
`timescale 1ns / 1ps
module osst_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                             clk,
  input  osst_pkg::cell_ctrl_t             ctrl,
  input  logic [CNT_W-1:0]                 count,
  input  logic [osst_pkg::VALUE_W-1:0]     value,
  input  logic [osst_pkg::VALUE_W-1:0]     slot_up,
  input  logic                             seen_in,
  output logic                             seen_out,
  output logic [osst_pkg::VALUE_W-1:0]     slot_q
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [osst_pkg::VALUE_W-1:0] slot_r;
  logic                         hit_r;
  logic                         live;

  assign live     = IDX_C < count;
  assign seen_out = seen_in | hit_r;
  assign slot_q   = slot_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= live && (slot_r == value);
    end
    if (ctrl.upd_en) begin
      // remove: every cell at or above the hit takes its upper neighbor
      if (ctrl.remove && seen_out) begin
        slot_r <= slot_up;
      end else if (ctrl.add && (IDX_C == count)) begin
        slot_r <= value;
      end
    end
  end

endmodule

/* tb/ordered_set_store_test.sv */
`timescale 1ns / 1ps
module ordered_set_store_test;

  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned RANDOM_REQUESTS = 1800;

  typedef struct packed {
    logic                             found;
    logic                             changed;
    logic                             full_reject;
    logic [osst_pkg::OUT_COUNT_W-1:0] member_count;
    logic                             is_empty;
  } set_status_t;

  // reps > 1 walks value by stride; typed rows carry their own status
  typedef struct packed {
    osst_pkg::mode_t mode;
    logic [31:0]     value;
    logic [4:0]      reps;
    logic [31:0]     stride;
    logic            typed;
    set_status_t     want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 15;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{osst_pkg::MODE_LOOKUP, 32'h0000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
    '{osst_pkg::MODE_REMOVE, 32'h0000_0007, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
    '{osst_pkg::MODE_CLEAR,  32'h0000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1}},
    '{osst_pkg::MODE_ADD,    32'h8000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd1, 1'b0}},
    '{osst_pkg::MODE_ADD,    32'h7FFF_FFFF, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd2, 1'b0}},
    '{osst_pkg::MODE_ADD,    32'h7FFF_FFFF, 5'd1, 32'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd2, 1'b0}},
    '{osst_pkg::MODE_ADD,    32'hFFFF_FFFF, 5'd14, 32'hFFFF_FFFF, 1'b0, '0},
    '{osst_pkg::MODE_ADD,    32'h0000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b1, 5'd16, 1'b0}},
    '{osst_pkg::MODE_ADD,    32'h8000_0000, 5'd1, 32'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd16, 1'b0}},
    '{osst_pkg::MODE_REMOVE, 32'h8000_0000, 5'd1, 32'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd15, 1'b0}},
    '{osst_pkg::MODE_LOOKUP, 32'hFFFF_FFF9, 5'd1, 32'd0, 1'b0, '0},
    '{osst_pkg::MODE_LOOKUP, 32'h8000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd15, 1'b0}},
    '{osst_pkg::MODE_ADD,    32'h8000_0000, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd16, 1'b0}},
    '{osst_pkg::MODE_REMOVE, 32'hFFFF_FFF2, 5'd1, 32'd0, 1'b0, '0},
    '{osst_pkg::MODE_CLEAR,  32'hFFFF_FFFF, 5'd1, 32'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  osst_in_if  in_ch ();
  osst_out_if out_ch ();

  ordered_set_store u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0]  member_slots [osst_pkg::DEF_CAPACITY];
  int unsigned  member_total;
  set_status_t  awaited_status[$];
  logic [31:0]  value_pool [POOL_SIZE];
  int unsigned  requests_taken;
  int unsigned  statuses_seen;
  int unsigned  error_count;
  bit           calm;
  logic         hold_out;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] status %0d: %s", $realtime, statuses_seen, what);
  endtask

  function automatic set_status_t predict_set_op(input osst_pkg::mode_t mode,
                                                 input logic [31:0] value);
    set_status_t st;
    int          hit;
    st  = '0;
    hit = -1;
    for (int i = 0; i < int'(member_total); i++) begin
      if (hit < 0 && member_slots[i] == value) hit = i;
    end
    case (mode)
      osst_pkg::MODE_ADD: begin
        st.found = (hit >= 0);
        if (hit < 0) begin
          if (member_total < osst_pkg::DEF_CAPACITY) begin
            member_slots[member_total] = value;
            member_total++;
            st.changed = 1'b1;
          end else begin
            st.full_reject = 1'b1;
          end
        end
      end
      osst_pkg::MODE_REMOVE: begin
        st.found = (hit >= 0);
        if (hit >= 0) begin
          for (int i = hit; i + 1 < int'(member_total); i++) member_slots[i] = member_slots[i + 1];
          member_total--;
          st.changed = 1'b1;
        end
      end
      osst_pkg::MODE_LOOKUP: begin
        st.found = (hit >= 0);
      end
      default: begin
        st.changed   = (member_total != 0);
        member_total = 0;
      end
    endcase
    st.member_count = osst_pkg::OUT_COUNT_W'(member_total);
    st.is_empty     = (member_total == 0);
    return st;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic offer_request(input osst_pkg::mode_t mode, input logic [31:0] value,
                               input logic typed, input set_status_t want);
    int unsigned gap;
    set_status_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_set_op(mode, value);
    awaited_status.push_back(typed ? want : predicted);
    requests_taken++;
  endtask

  // result side
  initial begin
    set_status_t got;
    set_status_t want;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0 || hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_out) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.found, out_ch.changed, out_ch.full_reject, out_ch.member_count,
             out_ch.is_empty};
      statuses_seen++;
      if (awaited_status.size() == 0) begin
        report_mismatch("transfer with no request outstanding");
      end else begin
        want = awaited_status.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.changed !== want.changed)
          report_mismatch($sformatf("changed %b, want %b", got.changed, want.changed));
        if (got.full_reject !== want.full_reject)
          report_mismatch($sformatf("full_reject %b, want %b", got.full_reject,
                                    want.full_reject));
        if (got.member_count !== want.member_count)
          report_mismatch($sformatf("member_count %0d, want %0d", got.member_count,
                                    want.member_count));
        if (got.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      end
    end
  end

  // long backpressure so the block holds its result and stalls its input
  initial begin
    hold_out = 1'b0;
    while (requests_taken < 600) @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    osst_pkg::mode_t mode;
    logic [31:0]     value;
    int unsigned     pick;
    requests_taken = 0;
    statuses_seen  = 0;
    error_count    = 0;
    member_total   = 0;
    calm           = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= osst_pkg::MODE_ADD;
    in_ch.value <= '0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < int'(directed_rows[r].reps); k++) begin
        offer_request(directed_rows[r].mode,
                      directed_rows[r].value + 32'(k) * directed_rows[r].stride,
                      directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int n = 0; n < int'(RANDOM_REQUESTS); n++) begin
      if (n % 150 == 0) begin
        foreach (value_pool[p]) begin
          case (p % 4)
            0:       value_pool[p] = $urandom;
            1:       value_pool[p] = $urandom_range(0, 15);
            2:       value_pool[p] = -$urandom_range(1, 16);
            default: value_pool[p] = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                           : 32'h8000_0000 + $urandom_range(0, 3);
          endcase
        end
      end
      calm = (n % 400) < 60;

      pick = $urandom_range(0, 99);
      if (pick < 45)      mode = osst_pkg::MODE_ADD;
      else if (pick < 70) mode = osst_pkg::MODE_REMOVE;
      else if (pick < 97) mode = osst_pkg::MODE_LOOKUP;
      else                mode = osst_pkg::MODE_CLEAR;

      pick = $urandom_range(0, 9);
      if (pick < 4)
        value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 7 && member_total > 0)
        value = member_slots[$urandom_range(0, member_total - 1)];
      else
        value = $urandom;

      offer_request(mode, value, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (awaited_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && awaited_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
